@@ sv/vab_pkg.sv @@
// shared types, widths and tables for the vector angle pipeline
`default_nettype none
package vab_pkg;

    localparam int COMP_W_DEF   = 16;
    localparam int FRAC_DEF     = 8;

    localparam int MAG_W        = 16;
    localparam int MAG_LIMIT    = 32768;
    localparam int PROD_W       = 32;
    localparam int DOT_W        = 34;
    localparam int RAD_W        = 64;
    localparam int ROOT_W       = RAD_W / 2;
    localparam int REM_W        = ROOT_W + 2;
    localparam int XY_W         = 64;
    localparam int NORM_W       = XY_W - 3;
    localparam int ACC_FRAC     = 24;
    localparam int CORDIC_STEPS = 24;
    localparam int Z_W          = 34;

    localparam int PREP_ST      = 6;
    localparam int SQRT_ST      = ROOT_W;
    localparam int CORD_ST      = CORDIC_STEPS + 3;
    localparam int NUM_ST       = PREP_ST + SQRT_ST + CORD_ST;

    localparam logic signed [Z_W-1:0] DEG90_ACC  = Z_W'(longint'(90) <<< ACC_FRAC);
    localparam logic signed [Z_W-1:0] DEG180_ACC = Z_W'(longint'(180) <<< ACC_FRAC);

    typedef struct packed {
        logic dot_neg;
        logic degen;
    } vab_side_t;

    // atan(2^-i) in units of 2^-24 degree
    function automatic logic signed [Z_W-1:0] atan_tab(input int unsigned idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            0:       v = Z_W'(754974720);
            1:       v = Z_W'(445687602);
            2:       v = Z_W'(235489088);
            3:       v = Z_W'(119537938);
            4:       v = Z_W'(60000934);
            5:       v = Z_W'(30029717);
            6:       v = Z_W'(15018523);
            7:       v = Z_W'(7509720);
            8:       v = Z_W'(3754917);
            9:       v = Z_W'(1877466);
            10:      v = Z_W'(938734);
            11:      v = Z_W'(469367);
            12:      v = Z_W'(234684);
            13:      v = Z_W'(117342);
            14:      v = Z_W'(58671);
            15:      v = Z_W'(29335);
            16:      v = Z_W'(14668);
            17:      v = Z_W'(7334);
            18:      v = Z_W'(3667);
            19:      v = Z_W'(1833);
            20:      v = Z_W'(917);
            21:      v = Z_W'(458);
            22:      v = Z_W'(229);
            23:      v = Z_W'(115);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

@@ sv/vab_pipe_ctrl.sv @@
// valid bits and per-stage load enables with bubble collapse
`default_nettype none
module vab_pipe_ctrl
    import vab_pkg::*;
#(
    parameter int STAGES = NUM_ST
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              out_stall,
    output logic                   in_stall,
    output logic [STAGES-1:0]      stage_en,
    output logic                   out_valid
);

    logic [STAGES-1:0] valid_reg;
    logic [STAGES:0]   ready;

    always_comb
    begin
        ready[STAGES] = ~out_stall;
        for (int i = STAGES - 1; i >= 0; i--)
        begin
            ready[i] = ~valid_reg[i] | ready[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (ready[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int i = 1; i < STAGES; i++)
            begin
                if (ready[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    assign stage_en  = ready[STAGES-1:0];
    assign in_stall  = ~ready[0];
    assign out_valid = valid_reg[STAGES-1];

endmodule
`default_nettype wire

@@ sv/vab_prep.sv @@
// magnitudes, scaling, dot product, squared norms and squared cross magnitude
`default_nettype none
module vab_prep
    import vab_pkg::*;
#(
    parameter int COMPONENT_WIDTH = COMP_W_DEF
)
(
    input  wire logic                              clk,
    input  wire logic [PREP_ST-1:0]                en,
    input  wire logic signed [COMPONENT_WIDTH-1:0] a_x,
    input  wire logic signed [COMPONENT_WIDTH-1:0] a_y,
    input  wire logic signed [COMPONENT_WIDTH-1:0] a_z,
    input  wire logic signed [COMPONENT_WIDTH-1:0] b_x,
    input  wire logic signed [COMPONENT_WIDTH-1:0] b_y,
    input  wire logic signed [COMPONENT_WIDTH-1:0] b_z,
    output logic [RAD_W-1:0]                       c2,
    output logic [PROD_W-1:0]                      dabs,
    output vab_side_t                              side
);

    localparam int CW     = COMPONENT_WIDTH;
    localparam int EW     = (CW > 17) ? CW : 17;
    localparam int SH_MAX = (CW > MAG_W) ? CW - MAG_W : 0;
    localparam int SH_W   = (SH_MAX > 0) ? $clog2(SH_MAX + 1) : 1;

    // stage 0: sign and magnitude
    logic [CW-1:0]  raw [6];
    logic [CW-1:0]  mag0_next [6];
    logic [CW-1:0]  mag0_reg [6];
    logic [5:0]     neg0_next;
    logic [5:0]     neg0_reg;

    assign raw[0] = a_x;
    assign raw[1] = a_y;
    assign raw[2] = a_z;
    assign raw[3] = b_x;
    assign raw[4] = b_y;
    assign raw[5] = b_z;

    always_comb
    begin
        for (int j = 0; j < 6; j++)
        begin
            neg0_next[j] = raw[j][CW-1];
            mag0_next[j] = raw[j][CW-1] ? (~raw[j] + 1'b1) : raw[j];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            mag0_reg  <= mag0_next;
            neg0_reg  <= neg0_next;
        end
    end

    // stage 1: per-vector power-of-two scaling to at most 2^15
    logic [EW-1:0]    mx [2];
    logic [SH_W-1:0]  sh [2];
    logic [MAG_W-1:0] mag1_next [6];
    logic [MAG_W-1:0] mag1_reg [6];
    logic [5:0]       neg1_reg;
    logic             degen1_next;
    logic             degen1_reg;

    always_comb
    begin
        for (int v = 0; v < 2; v++)
        begin
            mx[v] = EW'(mag0_reg[3*v]);
            if (EW'(mag0_reg[3*v+1]) > mx[v])
            begin
                mx[v] = EW'(mag0_reg[3*v+1]);
            end
            if (EW'(mag0_reg[3*v+2]) > mx[v])
            begin
                mx[v] = EW'(mag0_reg[3*v+2]);
            end
            sh[v] = '0;
            for (int s = SH_MAX; s >= 0; s--)
            begin
                if ((mx[v] >> s) <= EW'(MAG_LIMIT))
                begin
                    sh[v] = SH_W'(s);
                end
            end
        end
        for (int j = 0; j < 6; j++)
        begin
            mag1_next[j] = MAG_W'(EW'(mag0_reg[j]) >> sh[j/3]);
        end
        degen1_next = ((mag1_next[0] | mag1_next[1] | mag1_next[2]) == '0) ||
                      ((mag1_next[3] | mag1_next[4] | mag1_next[5]) == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            mag1_reg   <= mag1_next;
            neg1_reg   <= neg0_reg;
            degen1_reg <= degen1_next;
        end
    end

    // stage 2: component products
    logic [PROD_W-1:0] pa_reg [3];
    logic [PROD_W-1:0] pb_reg [3];
    logic [PROD_W-1:0] pab_reg [3];
    logic [2:0]        sgn2_reg;
    logic              degen2_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            for (int i = 0; i < 3; i++)
            begin
                pa_reg[i]   <= PROD_W'(mag1_reg[i]) * PROD_W'(mag1_reg[i]);
                pb_reg[i]   <= PROD_W'(mag1_reg[i+3]) * PROD_W'(mag1_reg[i+3]);
                pab_reg[i]  <= PROD_W'(mag1_reg[i]) * PROD_W'(mag1_reg[i+3]);
                sgn2_reg[i] <= neg1_reg[i] ^ neg1_reg[i+3];
            end
            degen2_reg <= degen1_reg;
        end
    end

    // stage 3: sums and dot magnitude
    logic signed [DOT_W-1:0] dot_next;
    logic [PROD_W-1:0]       na_reg;
    logic [PROD_W-1:0]       nb_reg;
    logic [PROD_W-1:0]       dabs3_reg;
    vab_side_t               side3_reg;

    always_comb
    begin
        dot_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (sgn2_reg[i])
            begin
                dot_next = dot_next - signed'(DOT_W'(pab_reg[i]));
            end
            else
            begin
                dot_next = dot_next + signed'(DOT_W'(pab_reg[i]));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            na_reg          <= pa_reg[0] + pa_reg[1] + pa_reg[2];
            nb_reg          <= pb_reg[0] + pb_reg[1] + pb_reg[2];
            dabs3_reg       <= dot_next[DOT_W-1] ? PROD_W'(-dot_next) : PROD_W'(dot_next);
            side3_reg.dot_neg <= dot_next[DOT_W-1];
            side3_reg.degen   <= degen2_reg;
        end
    end

    // stage 4: |a|^2 |b|^2 and (a.b)^2
    logic [RAD_W-1:0]  pn_reg;
    logic [RAD_W-1:0]  pd_reg;
    logic [PROD_W-1:0] dabs4_reg;
    vab_side_t         side4_reg;

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            pn_reg    <= RAD_W'(na_reg) * RAD_W'(nb_reg);
            pd_reg    <= RAD_W'(dabs3_reg) * RAD_W'(dabs3_reg);
            dabs4_reg <= dabs3_reg;
            side4_reg <= side3_reg;
        end
    end

    // stage 5: squared cross magnitude
    logic [RAD_W-1:0]  c2_reg;
    logic [PROD_W-1:0] dabs5_reg;
    vab_side_t         side5_reg;

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            c2_reg    <= pn_reg - pd_reg;
            dabs5_reg <= dabs4_reg;
            side5_reg <= side4_reg;
        end
    end

    assign c2   = c2_reg;
    assign dabs = dabs5_reg;
    assign side = side5_reg;

endmodule
`default_nettype wire

@@ sv/vab_isqrt.sv @@
// pipelined integer square root, one root bit per stage
`default_nettype none
module vab_isqrt
    import vab_pkg::*;
(
    input  wire logic               clk,
    input  wire logic [SQRT_ST-1:0] en,
    input  wire logic [RAD_W-1:0]   rad_i,
    input  wire logic [PROD_W-1:0]  dabs_i,
    input  wire vab_side_t          side_i,
    output logic [ROOT_W-1:0]       root_o,
    output logic [PROD_W-1:0]       dabs_o,
    output vab_side_t               side_o
);

    logic [RAD_W-1:0]  rad_reg [SQRT_ST];
    logic [REM_W-1:0]  rem_reg [SQRT_ST];
    logic [ROOT_W-1:0] q_reg [SQRT_ST];
    logic [PROD_W-1:0] dabs_reg [SQRT_ST];
    vab_side_t         side_reg [SQRT_ST];

    for (genvar k = 0; k < SQRT_ST; k++)
    begin : g_bit
        logic [RAD_W-1:0]   rad_in;
        logic [REM_W-1:0]   rem_in;
        logic [ROOT_W-1:0]  q_in;
        logic [PROD_W-1:0]  dabs_in;
        vab_side_t          side_in;
        logic [REM_W+1:0]   rr;
        logic [REM_W+1:0]   trial;
        logic [REM_W-1:0]   rem_next;
        logic [ROOT_W-1:0]  q_next;

        if (k == 0)
        begin : g_first
            assign rad_in  = rad_i;
            assign rem_in  = '0;
            assign q_in    = '0;
            assign dabs_in = dabs_i;
            assign side_in = side_i;
        end
        else
        begin : g_next
            assign rad_in  = rad_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign q_in    = q_reg[k-1];
            assign dabs_in = dabs_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        always_comb
        begin
            rr    = {rem_in, rad_in[RAD_W-1:RAD_W-2]};
            trial = (REM_W+2)'({q_in, 2'b01});
            if (rr >= trial)
            begin
                rem_next = REM_W'(rr - trial);
                q_next   = {q_in[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = REM_W'(rr);
                q_next   = {q_in[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                rad_reg[k]  <= {rad_in[RAD_W-3:0], 2'b00};
                rem_reg[k]  <= rem_next;
                q_reg[k]    <= q_next;
                dabs_reg[k] <= dabs_in;
                side_reg[k] <= side_in;
            end
        end
    end

    assign root_o = q_reg[SQRT_ST-1];
    assign dabs_o = dabs_reg[SQRT_ST-1];
    assign side_o = side_reg[SQRT_ST-1];

endmodule
`default_nettype wire

@@ sv/vab_cordic.sv @@
// normalisation, vectoring cordic in degrees, clamp, reflection and rounding
`default_nettype none
module vab_cordic
    import vab_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = FRAC_DEF
)
(
    input  wire logic                       clk,
    input  wire logic [CORD_ST-1:0]         en,
    input  wire logic [PROD_W-1:0]          dabs_i,
    input  wire logic [ROOT_W-1:0]          root_i,
    input  wire vab_side_t                  side_i,
    output logic [8+ANGLE_FRAC_BITS-1:0]    angle_o,
    output logic                            degen_o
);

    localparam int OUT_W     = 8 + ANGLE_FRAC_BITS;
    localparam int OUT_SHIFT = ACC_FRAC - ANGLE_FRAC_BITS;

    // normalise so the larger of x and y lies in [2^60, 2^61)
    logic [NORM_W-1:0] nxa_next, nya_next, nxa_reg, nya_reg;
    logic [NORM_W-1:0] nxb_next, nyb_next, nxb_reg, nyb_reg;
    vab_side_t         sidea_reg, sideb_reg;

    always_comb
    begin
        nxa_next = NORM_W'(dabs_i);
        nya_next = NORM_W'(root_i);
        for (int step = 32; step >= 8; step = step >> 1)
        begin
            if (((nxa_next | nya_next) >> (NORM_W - step)) == '0)
            begin
                nxa_next = nxa_next << step;
                nya_next = nya_next << step;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            nxa_reg   <= nxa_next;
            nya_reg   <= nya_next;
            sidea_reg <= side_i;
        end
    end

    always_comb
    begin
        nxb_next = nxa_reg;
        nyb_next = nya_reg;
        for (int step = 4; step >= 1; step = step >> 1)
        begin
            if (((nxb_next | nyb_next) >> (NORM_W - step)) == '0)
            begin
                nxb_next = nxb_next << step;
                nyb_next = nyb_next << step;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            nxb_reg   <= nxb_next;
            nyb_reg   <= nyb_next;
            sideb_reg <= sidea_reg;
        end
    end

    // one micro-rotation per stage
    logic signed [XY_W-1:0] x_reg [CORDIC_STEPS];
    logic signed [XY_W-1:0] y_reg [CORDIC_STEPS];
    logic signed [Z_W-1:0]  z_reg [CORDIC_STEPS];
    vab_side_t              side_reg [CORDIC_STEPS];

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_iter
        logic signed [XY_W-1:0] x_in, y_in, dx, dy;
        logic signed [Z_W-1:0]  z_in;
        vab_side_t              side_in;

        if (i == 0)
        begin : g_first
            assign x_in    = signed'(XY_W'(nxb_reg));
            assign y_in    = signed'(XY_W'(nyb_reg));
            assign z_in    = '0;
            assign side_in = sideb_reg;
        end
        else
        begin : g_next
            assign x_in    = x_reg[i-1];
            assign y_in    = y_reg[i-1];
            assign z_in    = z_reg[i-1];
            assign side_in = side_reg[i-1];
        end

        assign dx = y_in >>> i;
        assign dy = x_in >>> i;

        always_ff @(posedge clk)
        begin
            if (en[i+2])
            begin
                if (!y_in[XY_W-1])
                begin
                    x_reg[i] <= x_in + dx;
                    y_reg[i] <= y_in - dy;
                    z_reg[i] <= z_in + atan_tab(i);
                end
                else
                begin
                    x_reg[i] <= x_in - dx;
                    y_reg[i] <= y_in + dy;
                    z_reg[i] <= z_in - atan_tab(i);
                end
                side_reg[i] <= side_in;
            end
        end
    end

    // clamp to the first quadrant, reflect for an obtuse angle, round half up
    logic signed [Z_W-1:0] zc;
    logic signed [Z_W-1:0] theta;
    logic [Z_W-1:0]        rnd;
    logic [OUT_W-1:0]      angle_next;
    logic [OUT_W-1:0]      angle_reg;
    logic                  degen_reg;
    vab_side_t             side_last;

    assign side_last = side_reg[CORDIC_STEPS-1];

    always_comb
    begin
        zc = z_reg[CORDIC_STEPS-1];
        if (zc < 0)
        begin
            zc = '0;
        end
        else if (zc > DEG90_ACC)
        begin
            zc = DEG90_ACC;
        end
        theta = side_last.dot_neg ? (DEG180_ACC - zc) : zc;
        rnd   = $unsigned(theta) + (Z_W'(1) << (OUT_SHIFT - 1));
        angle_next = side_last.degen ? '0 : OUT_W'(rnd >> OUT_SHIFT);
    end

    always_ff @(posedge clk)
    begin
        if (en[CORD_ST-1])
        begin
            angle_reg <= angle_next;
            degen_reg <= side_last.degen;
        end
    end

    assign angle_o = angle_reg;
    assign degen_o = degen_reg;

endmodule
`default_nettype wire

@@ sv/vector_angle_between_3d.sv @@
// pipeline: 6 prep, 32 root and 27 cordic stages between input transfer and result
// throughput: one transfer per cycle while in_stall is low, set by the one-bit-per-stage root and cordic stages
// a stalled output fills empty stages first, so input stalls only when all stages hold items
// reset: rst_n clears the stage valid bits asynchronously, datapath registers keep no reset
// no configuration and no state between items
`default_nettype none
module vector_angle_between_3d
    import vab_pkg::*;
#(
    parameter int COMPONENT_WIDTH = COMP_W_DEF,
    parameter int ANGLE_FRAC_BITS = FRAC_DEF
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic signed [COMPONENT_WIDTH-1:0] a_x,
    input  wire logic signed [COMPONENT_WIDTH-1:0] a_y,
    input  wire logic signed [COMPONENT_WIDTH-1:0] a_z,
    input  wire logic signed [COMPONENT_WIDTH-1:0] b_x,
    input  wire logic signed [COMPONENT_WIDTH-1:0] b_y,
    input  wire logic signed [COMPONENT_WIDTH-1:0] b_z,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [8+ANGLE_FRAC_BITS-1:0]           angle_deg,
    output logic                                   degenerate
);

    localparam int OUT_W = 8 + ANGLE_FRAC_BITS;

    logic [NUM_ST-1:0] stage_en;
    logic [RAD_W-1:0]  c2;
    logic [PROD_W-1:0] dabs_p, dabs_s;
    logic [ROOT_W-1:0] root;
    vab_side_t         side_p, side_s;

    vab_pipe_ctrl #(
        .STAGES    (NUM_ST)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .in_stall  (in_stall),
        .stage_en  (stage_en),
        .out_valid (out_valid)
    );

    vab_prep #(
        .COMPONENT_WIDTH (COMPONENT_WIDTH)
    ) u_prep (
        .clk  (clk),
        .en   (stage_en[PREP_ST-1:0]),
        .a_x  (a_x),
        .a_y  (a_y),
        .a_z  (a_z),
        .b_x  (b_x),
        .b_y  (b_y),
        .b_z  (b_z),
        .c2   (c2),
        .dabs (dabs_p),
        .side (side_p)
    );

    vab_isqrt u_isqrt (
        .clk    (clk),
        .en     (stage_en[PREP_ST+SQRT_ST-1:PREP_ST]),
        .rad_i  (c2),
        .dabs_i (dabs_p),
        .side_i (side_p),
        .root_o (root),
        .dabs_o (dabs_s),
        .side_o (side_s)
    );

    vab_cordic #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_cordic (
        .clk     (clk),
        .en      (stage_en[NUM_ST-1:PREP_ST+SQRT_ST]),
        .dabs_i  (dabs_s),
        .root_i  (root),
        .side_i  (side_s),
        .angle_o (angle_deg),
        .degen_o (degenerate)
    );

`ifndef SYNTHESIS
    localparam logic [OUT_W:0] ANGLE_MAX = (OUT_W+1)'(180) << ANGLE_FRAC_BITS;

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> angle_deg == '0)
        else $error("degenerate result with nonzero angle");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (OUT_W+1)'(angle_deg) <= ANGLE_MAX)
        else $error("angle above 180 degrees");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while the pipeline can still move");
`endif

endmodule
`default_nettype wire
